@@ hdl/ahr_pkg.sv @@
`default_nettype none
package ahr_pkg;

	localparam int NUM_BINS    = 16;
	localparam int COUNT_WIDTH = 32;
	localparam int IDX_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

	// log2 of bin size; the size stops growing at 2^SHIFT_LIMIT
	localparam int SHIFT_W     = 5;
	localparam int SHIFT_LIMIT = 31;

	localparam int SAMPLE_W    = 32;
	localparam int VALUE_W     = SAMPLE_W - 1;

	// result fields
	localparam int BIN_INDEX_W    = 4;
	localparam int BIN_LOW_W      = 31;
	localparam int BIN_HIGH_W     = 32;
	localparam int BIN_COUNT_W    = 32;
	localparam int WIDTH_OF_BIN_W = 28;
	localparam int OUT_FIELDS_W   = BIN_INDEX_W + BIN_LOW_W + BIN_HIGH_W + BIN_COUNT_W
		+ WIDTH_OF_BIN_W;
	localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W      = OUT_DATA_W - OUT_FIELDS_W;

	// bin bounds are formed in a word wide enough for index << largest shift
	localparam int SPAN_W = IDX_W + (1 << SHIFT_W);

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_DUMP   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DUMP
	} state_t;

	// per-cycle command broadcast to every cell of the row
	typedef struct packed {
		logic merge;
		logic rotate;
		logic inc;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/ahr_cell.sv @@
`default_nettype none
module ahr_cell (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  ahr_pkg::cell_ctrl_t                   ctrl,
	input  wire                                   inc_sel,
	input  wire  [ahr_pkg::COUNT_WIDTH-1:0]       pair_a,
	input  wire  [ahr_pkg::COUNT_WIDTH-1:0]       pair_b,
	input  wire  [ahr_pkg::COUNT_WIDTH-1:0]       next_count,
	output logic [ahr_pkg::COUNT_WIDTH-1:0]       count
);

	logic [ahr_pkg::COUNT_WIDTH-1:0] count_q;
	logic [ahr_pkg::COUNT_WIDTH:0]   pair_sum;
	logic [ahr_pkg::COUNT_WIDTH:0]   inc_sum;
	logic [ahr_pkg::COUNT_WIDTH-1:0] merged;
	logic [ahr_pkg::COUNT_WIDTH-1:0] bumped;

	// saturating pair sum and saturating increment
	always_comb begin
		pair_sum = {1'b0, pair_a} + {1'b0, pair_b};
		inc_sum  = {1'b0, count_q} + {{ahr_pkg::COUNT_WIDTH{1'b0}}, 1'b1};
		merged   = pair_sum[ahr_pkg::COUNT_WIDTH] ? {ahr_pkg::COUNT_WIDTH{1'b1}}
			: pair_sum[ahr_pkg::COUNT_WIDTH-1:0];
		bumped   = inc_sum[ahr_pkg::COUNT_WIDTH] ? count_q
			: inc_sum[ahr_pkg::COUNT_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			priority if (ctrl.merge) begin
				count_q <= merged;
			end else if (ctrl.rotate) begin
				count_q <= next_count;
			end else if (ctrl.inc && inc_sel) begin
				count_q <= bumped;
			end else begin
				count_q <= count_q;
			end
		end
	end

	assign count = count_q;

endmodule
`default_nettype wire

@@ hdl/auto_ranging_histogram.sv @@
`default_nettype none
// Auto-ranging histogram: a row of NUM_BINS saturating counters covering 0 up to
// NUM_BINS times the bin size, which starts at 1. A sample transfer (tuser = 0)
// with a negative value is dropped. A nonnegative sample is accepted, then
// every doubling of the bin size it forces merges adjacent bin pairs in the
// row, then its bin is updated. A dump transfer (tuser = 1) produces NUM_BINS
// result transfers, bin 0 first, tlast on the final one; while the output
// register is free the counter row rotates one place per cycle toward cell 0,
// so a dump is accepted, then gives one result per bin, and leaves the
// counters as they were. The input is taken only while no item is in
// progress; the last dump result may still sit in the output register while
// the next item is accepted.
module auto_ranging_histogram (
	input  wire                               clk,
	input  wire                               arst_n,

	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// [31:0] sample (signed)
	input  wire  [ahr_pkg::SAMPLE_W-1:0]      s_axis_tdata,
	// [0] kind: 0 add sample, 1 dump all bins
	input  wire                               s_axis_tuser,

	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// [3:0] bin_index, [34:4] bin_low, [66:35] bin_high, [98:67] bin_count,
	// [126:99] width_of_bin, [127] zero
	output logic [ahr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                              m_axis_tlast
);

	ahr_pkg::state_t                  state_q, state_nxt;
	logic [ahr_pkg::SHIFT_W-1:0]      size_shift_q;
	logic [ahr_pkg::VALUE_W-1:0]      val_q;      // sample >> size_shift, kept aligned
	logic [ahr_pkg::IDX_W-1:0]        dump_cnt_q;

	logic                             m_valid_q;
	logic                             out_last_q;
	logic [ahr_pkg::BIN_INDEX_W-1:0]  out_index_q;
	logic [ahr_pkg::BIN_LOW_W-1:0]    out_low_q;
	logic [ahr_pkg::BIN_HIGH_W-1:0]   out_high_q;
	logic [ahr_pkg::BIN_COUNT_W-1:0]  out_count_q;
	logic [ahr_pkg::WIDTH_OF_BIN_W-1:0] out_width_q;

	logic                             in_xfer;
	logic                             out_free;
	logic                             need_merge;
	logic                             val_over;
	logic                             dump_end;
	logic [ahr_pkg::IDX_W-1:0]        inc_idx;
	ahr_pkg::cell_ctrl_t              ctrl;
	logic                             load_out;

	logic [ahr_pkg::COUNT_WIDTH-1:0]  counts [ahr_pkg::NUM_BINS];
	logic [ahr_pkg::SPAN_W-1:0]       lo_full;
	logic [ahr_pkg::SPAN_W-1:0]       size_full;
	logic [ahr_pkg::SPAN_W-1:0]       high_full;
	logic [ahr_pkg::COUNT_WIDTH+ahr_pkg::BIN_COUNT_W-1:0] head_ext;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign val_over = (val_q >= ahr_pkg::VALUE_W'(ahr_pkg::NUM_BINS));
	// grow the range while the value lies beyond the top bin and the shift is below its limit
	assign need_merge = val_over
		&& (size_shift_q < ahr_pkg::SHIFT_W'(ahr_pkg::SHIFT_LIMIT));
	// only reachable at the shift limit: clamp into the top bin
	assign inc_idx  = val_over ? ahr_pkg::IDX_W'(ahr_pkg::NUM_BINS - 1)
		: val_q[ahr_pkg::IDX_W-1:0];
	assign dump_end = (dump_cnt_q == ahr_pkg::IDX_W'(ahr_pkg::NUM_BINS - 1));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ahr_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (s_axis_tuser == ahr_pkg::KIND_DUMP) begin
						state_nxt = ahr_pkg::ST_DUMP;
					end else if (!s_axis_tdata[ahr_pkg::SAMPLE_W-1]) begin
						state_nxt = ahr_pkg::ST_CHECK;
					end
				end
			end
			ahr_pkg::ST_CHECK: begin
				if (!need_merge) begin
					state_nxt = ahr_pkg::ST_IDLE;
				end
			end
			ahr_pkg::ST_DUMP: begin
				if (out_free && dump_end) begin
					state_nxt = ahr_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ahr_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		ctrl          = '0;
		load_out      = 1'b0;
		unique case (state_q)
			ahr_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ahr_pkg::ST_CHECK: begin
				ctrl.merge = need_merge;
				ctrl.inc   = !need_merge;
			end
			ahr_pkg::ST_DUMP: begin
				ctrl.rotate = out_free;
				load_out    = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ahr_pkg::ST_IDLE;
			size_shift_q <= '0;
			dump_cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.merge) begin
				size_shift_q <= size_shift_q + ahr_pkg::SHIFT_W'(1);
			end
			if (in_xfer) begin
				dump_cnt_q <= '0;
			end else if (load_out) begin
				dump_cnt_q <= dump_cnt_q + ahr_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			val_q <= s_axis_tdata[ahr_pkg::VALUE_W-1:0] >> size_shift_q;
		end else if (ctrl.merge) begin
			val_q <= val_q >> 1;
		end
	end

	// row of counter cells; pairs feed the merge, neighbor feeds the rotation
	for (genvar i = 0; i < ahr_pkg::NUM_BINS; i++) begin : g_cell
		logic [ahr_pkg::COUNT_WIDTH-1:0] pa;
		logic [ahr_pkg::COUNT_WIDTH-1:0] pb;
		if (2 * i < ahr_pkg::NUM_BINS) begin : g_pa
			assign pa = counts[2 * i];
		end else begin : g_pa0
			assign pa = '0;
		end
		if (2 * i + 1 < ahr_pkg::NUM_BINS) begin : g_pb
			assign pb = counts[2 * i + 1];
		end else begin : g_pb0
			assign pb = '0;
		end
		ahr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.inc_sel    (inc_idx == ahr_pkg::IDX_W'(i)),
			.pair_a     (pa),
			.pair_b     (pb),
			.next_count (counts[(i + 1) % ahr_pkg::NUM_BINS]),
			.count      (counts[i])
		);
	end

	// bin bounds of the bin at the head of the row
	always_comb begin
		lo_full   = ahr_pkg::SPAN_W'(dump_cnt_q) << size_shift_q;
		size_full = ahr_pkg::SPAN_W'(1) << size_shift_q;
		high_full = lo_full + size_full - ahr_pkg::SPAN_W'(1);
		head_ext  = {{ahr_pkg::BIN_COUNT_W{1'b0}}, counts[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_index_q <= ahr_pkg::BIN_INDEX_W'(dump_cnt_q);
			out_low_q   <= lo_full[ahr_pkg::BIN_LOW_W-1:0];
			out_high_q  <= high_full[ahr_pkg::BIN_HIGH_W-1:0];
			out_count_q <= head_ext[ahr_pkg::BIN_COUNT_W-1:0];
			out_width_q <= size_full[ahr_pkg::WIDTH_OF_BIN_W-1:0];
			out_last_q  <= dump_end;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{ahr_pkg::OUT_PAD_W{1'b0}}, out_width_q, out_count_q, out_high_q,
		out_low_q, out_index_q};

	// bin size never shrinks
	a_shift_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> size_shift_q >= $past(size_shift_q))
		else $error("bin size shrank");

	// final result of a dump describes the top bin
	a_last_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && out_last_q
		|-> out_index_q == ahr_pkg::BIN_INDEX_W'(ahr_pkg::NUM_BINS - 1))
		else $error("tlast on wrong bin");

	// a merge always halves the aligned value
	a_merge_halves: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.merge |=> val_q == ($past(val_q) >> 1))
		else $error("value not realigned after merge");

	// counters only move while the input side is closed
	a_busy_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.merge || ctrl.inc || ctrl.rotate) |-> !s_axis_tready)
		else $error("input open during update");

endmodule
`default_nettype wire

@@ verif/histogram_checker.sv @@
module histogram_checker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	input  wire                              s_axis_tready,
	input  wire  [ahr_pkg::SAMPLE_W-1:0]     s_axis_tdata,
	input  wire                              s_axis_tuser,
	input  wire                              m_axis_tvalid,
	input  wire                              m_axis_tready,
	input  wire  [ahr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  wire                              m_axis_tlast,
	output int                               failures,
	output int                               rows_due
);

	// same layout as m_axis_tdata, lowest field last
	typedef struct packed {
		logic [ahr_pkg::WIDTH_OF_BIN_W-1:0] size;
		logic [ahr_pkg::BIN_COUNT_W-1:0]    count;
		logic [ahr_pkg::BIN_HIGH_W-1:0]     high;
		logic [ahr_pkg::BIN_LOW_W-1:0]      low;
		logic [ahr_pkg::BIN_INDEX_W-1:0]    idx;
	} bin_row_t;

	logic [ahr_pkg::COUNT_WIDTH-1:0] bin_tally [ahr_pkg::NUM_BINS];
	logic [ahr_pkg::SHIFT_W-1:0]     range_shift;
	bin_row_t                        dump_rows_due [$];

	function automatic logic [ahr_pkg::COUNT_WIDTH-1:0] sat_sum(
			input logic [ahr_pkg::COUNT_WIDTH-1:0] a,
			input logic [ahr_pkg::COUNT_WIDTH-1:0] b);
		logic [ahr_pkg::COUNT_WIDTH:0] s;
		s = a + b;
		return s[ahr_pkg::COUNT_WIDTH] ? '1 : s[ahr_pkg::COUNT_WIDTH-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [ahr_pkg::SAMPLE_W-1:0]    v;
		logic [ahr_pkg::COUNT_WIDTH-1:0] merged [ahr_pkg::NUM_BINS];
		logic [ahr_pkg::COUNT_WIDTH-1:0] partner;
		logic [63:0]                     size, lo, bin;
		bin_row_t                        row, got;
		if (!arst_n) begin
			foreach (bin_tally[k]) bin_tally[k] = '0;
			range_shift = '0;
			dump_rows_due.delete();
			failures = 0;
		end else begin
			// input side first: a dump's rows can never leave on its own accept edge
			if (s_axis_tvalid && s_axis_tready) begin
				v = s_axis_tdata;
				if (s_axis_tuser == ahr_pkg::KIND_DUMP) begin
					size = 64'd1 << range_shift;
					for (int k = 0; k < ahr_pkg::NUM_BINS; k++) begin
						lo = 64'(k) * size;
						row.idx   = ahr_pkg::BIN_INDEX_W'(k);
						row.low   = lo[ahr_pkg::BIN_LOW_W-1:0];
						row.high  = ahr_pkg::BIN_HIGH_W'(lo + size - 64'd1);
						row.count = ahr_pkg::BIN_COUNT_W'(bin_tally[k]);
						row.size  = size[ahr_pkg::WIDTH_OF_BIN_W-1:0];
						dump_rows_due.push_back(row);
					end
				end else if (!v[ahr_pkg::SAMPLE_W-1]) begin
					// grow the range until the sample fits or the limit is hit, merging adjacent bin pairs each time
					while (range_shift < ahr_pkg::SHIFT_LIMIT &&
							64'(v) >= (64'(ahr_pkg::NUM_BINS) << range_shift)) begin
						range_shift++;
						foreach (merged[k]) merged[k] = '0;
						for (int k = 0; 2 * k < ahr_pkg::NUM_BINS; k++) begin
							partner = (2 * k + 1 < ahr_pkg::NUM_BINS) ? bin_tally[2 * k + 1]
								: '0;
							merged[k] = sat_sum(bin_tally[2 * k], partner);
						end
						bin_tally = merged;
					end
					bin = 64'(v) >> range_shift;
					if (bin >= 64'(ahr_pkg::NUM_BINS))
						bin = 64'(ahr_pkg::NUM_BINS - 1);
					bin_tally[bin] = sat_sum(bin_tally[bin], ahr_pkg::COUNT_WIDTH'(1));
				end
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[ahr_pkg::OUT_FIELDS_W-1:0];
				if (dump_rows_due.size() == 0) begin
					$error("unexpected result transfer: bin_index %0d bin_count %0d",
						got.idx, got.count);
					failures++;
				end else begin
					row = dump_rows_due.pop_front();
					if (got.idx !== row.idx) begin
						$error("bin_index: expected %0d, actual %0d", row.idx, got.idx);
						failures++;
					end
					if (got.low !== row.low) begin
						$error("bin_low: expected %0d, actual %0d", row.low, got.low);
						failures++;
					end
					if (got.high !== row.high) begin
						$error("bin_high: expected %0d, actual %0d", row.high, got.high);
						failures++;
					end
					if (got.count !== row.count) begin
						$error("bin_count: expected %0d, actual %0d", row.count, got.count);
						failures++;
					end
					if (got.size !== row.size) begin
						$error("width_of_bin: expected %0d, actual %0d", row.size, got.size);
						failures++;
					end
					if (m_axis_tlast !== (row.idx == ahr_pkg::NUM_BINS - 1)) begin
						$error("last: expected %0d, actual %0d",
							row.idx == ahr_pkg::NUM_BINS - 1, m_axis_tlast);
						failures++;
					end
				end
			end
		end
		rows_due = dump_rows_due.size();
	end

endmodule

@@ verif/testbench.sv @@
module testbench;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [ahr_pkg::SAMPLE_W-1:0]   s_axis_tdata;
	logic                           s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [ahr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tlast;

	int failures;
	int rows_due;
	int rows_seen;
	int samples_sent, negatives_sent, dumps_sent;
	bit calm;           // no new random gaps on either side while set
	bit held;

	auto_ranging_histogram uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	histogram_checker check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.failures      (failures),
		.rows_due      (rows_due)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one input transfer; returns at the edge where it is taken
	task automatic offer(input logic kind, input logic [ahr_pkg::SAMPLE_W-1:0] value);
		int gap;
		gap = calm ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tdata  = value;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (kind == ahr_pkg::KIND_DUMP)
			dumps_sent++;
		else if (value[ahr_pkg::SAMPLE_W-1])
			negatives_sent++;
		else
			samples_sent++;
	endtask

	always @(posedge clk)
		if (m_axis_tvalid && m_axis_tready)
			rows_seen++;

	// result sink: random back-pressure plus one long hold once a few dumps are out
	initial begin
		int stall;
		stall = 0;
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held && rows_seen >= 100 && m_axis_tvalid) begin
				held = 1'b1;
				m_axis_tready = 1'b0;
				repeat (300) @(negedge clk);
			end
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				stall--;
			end else begin
				m_axis_tready = 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	initial begin
		#(8 * 1_000_000);
		$display("FAIL auto_ranging_histogram");
		$finish;
	end

	initial begin
		int e, r;
		logic [63:0] mask;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = ahr_pkg::KIND_SAMPLE;
		s_axis_tdata  = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty dump, in-range samples, single and double range growth,
		// dropped negatives at both ends of the negative range
		offer(ahr_pkg::KIND_DUMP, 32'hFFFF_FFFF);
		offer(ahr_pkg::KIND_SAMPLE, 32'd0);
		offer(ahr_pkg::KIND_SAMPLE, 32'd15);
		offer(ahr_pkg::KIND_SAMPLE, 32'd5);
		offer(ahr_pkg::KIND_DUMP, 32'd0);
		offer(ahr_pkg::KIND_SAMPLE, 32'd16);
		offer(ahr_pkg::KIND_SAMPLE, 32'd31);
		offer(ahr_pkg::KIND_SAMPLE, 32'd32);
		offer(ahr_pkg::KIND_SAMPLE, 32'hFFFF_FFFF);
		offer(ahr_pkg::KIND_SAMPLE, 32'h8000_0000);
		offer(ahr_pkg::KIND_DUMP, 32'h5A5A_5A5A);
		offer(ahr_pkg::KIND_SAMPLE, 32'd63);
		offer(ahr_pkg::KIND_SAMPLE, 32'd200);
		offer(ahr_pkg::KIND_DUMP, 32'd0);

		// random: the value span widens slowly so the range grows in steps
		for (int n = 0; n < 300; n++) begin
			calm = (n >= 150 && n < 190);
			e = 8 + n * 24 / 300;
			r = $urandom_range(0, 99);
			if (r < 12) begin
				offer(ahr_pkg::KIND_DUMP, $urandom);
			end else if (r < 22) begin
				offer(ahr_pkg::KIND_SAMPLE, $urandom | 32'h8000_0000);
			end else begin
				mask = (64'd1 << $urandom_range(0, e)) - 64'd1;
				offer(ahr_pkg::KIND_SAMPLE, $urandom & {1'b0, mask[ahr_pkg::SAMPLE_W-2:0]});
			end
		end
		calm = 1'b0;

		// largest sample drives the range to its widest
		offer(ahr_pkg::KIND_SAMPLE, 32'h7FFF_FFFF);
		offer(ahr_pkg::KIND_SAMPLE, 32'd0);
		offer(ahr_pkg::KIND_DUMP, 32'd0);

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait (rows_due == 0);
		repeat (40) @(posedge clk);

		$display("covered %0d samples, %0d dropped negatives, %0d dumps", samples_sent,
			negatives_sent, dumps_sent);
		$display("checked %0d bin rows, one long sink hold", rows_seen);
		if (failures == 0) begin
			$display("PASS auto_ranging_histogram");
		end else begin
			$display("FAIL auto_ranging_histogram");
		end
		$finish;
	end

endmodule
